/* design/rank_weighted_alias_sampler_core_assert.svh */
// Assertion macros for the rank weighted alias sampler.
// Used by the top level; no other dependencies.
`ifndef RANK_WEIGHTED_ALIAS_SAMPLER_CORE_ASSERT_SVH
`define RANK_WEIGHTED_ALIAS_SAMPLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RWAS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rwas assertion failed");
`define RWAS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rwas assertion failed");
`else
`define RWAS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define RWAS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/rwas_pkg.sv */
// Shared constants and controller/datapath interface types for the
// rank weighted alias sampler. No dependencies.
package rwas_pkg;

   localparam int MAX_POP_DEFAULT = 64;
   localparam int POP_W           = 7;
   localparam int POP_MAX_REG     = (1 << POP_W) - 1;
   localparam int RAND_W          = 16;
   localparam int CHOSEN_W        = 6;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_IDX_W       = CSR_ADDR_W - 2;

   localparam logic [POP_W-1:0]     POP_MIN      = 7'd2;
   localparam logic [POP_W-1:0]     POP_RESET    = 7'd50;
   localparam logic [CSR_IDX_W-1:0] CSR_POP_SIZE = '0;

   typedef struct packed {
      logic load_req;
      logic prep;
      logic init_wr;
      logic scan_clr;
      logic scan_rd;
      logic wr_lo;
      logic wr_hi;
      logic mul;
      logic tab_rd;
      logic out_ld;
   } rwas_cmd_type;

   typedef struct packed {
      logic cnt_last;
      logic all_zero;
      logic round_done;
   } rwas_sts_type;

endpackage

/* design/rwas_ctrl.sv */
// Sequencer for table build and sampling of the alias sampler.
// Depends on rwas_pkg; drives the datapath through rwas_cmd_type.
module rwas_ctrl import rwas_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  logic         cfg_wr,
   input  rwas_sts_type sts,
   output rwas_cmd_type cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PREP   = 4'd1;
   localparam logic [3:0] ST_INIT   = 4'd2;
   localparam logic [3:0] ST_SCAN   = 4'd3;
   localparam logic [3:0] ST_DRAIN  = 4'd4;
   localparam logic [3:0] ST_DECIDE = 4'd5;
   localparam logic [3:0] ST_WR_LO  = 4'd6;
   localparam logic [3:0] ST_WR_HI  = 4'd7;
   localparam logic [3:0] ST_MUL    = 4'd8;
   localparam logic [3:0] ST_RD     = 4'd9;
   localparam logic [3:0] ST_CMP    = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       table_ready_ff, table_ready_in;

   always_comb begin
      cmd            = '0;
      state_in       = state_ff;
      table_ready_in = table_ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = table_ready_ff ? ST_MUL : ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (sts.cnt_last) begin
               cmd.scan_clr = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.cnt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (sts.all_zero || sts.round_done) begin
               table_ready_in = 1'b1;
               state_in       = ST_MUL;
            end else begin
               state_in = ST_WR_LO;
            end
         end
         ST_WR_LO: begin
            cmd.wr_lo = 1'b1;
            state_in  = ST_WR_HI;
         end
         ST_WR_HI: begin
            cmd.wr_hi    = 1'b1;
            cmd.scan_clr = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RD;
         end
         ST_RD: begin
            cmd.tab_rd = 1'b1;
            state_in   = ST_CMP;
         end
         ST_CMP: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.out_ld = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cfg_wr) begin
         table_ready_in = 1'b0;
      end
      rsp_valid_in = cmd.out_ld | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         table_ready_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         table_ready_ff <= table_ready_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/rwas_dpath.sv */
// Datapath of the alias sampler: difference, alias and cutoff memories,
// min/max scan, slot multiply and cutoff compare. Depends on rwas_pkg.
module rwas_dpath import rwas_pkg::*; #(
   parameter int MAX_POP = MAX_POP_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  rwas_cmd_type        cmd,
   output rwas_sts_type        sts,
   input  logic [POP_W-1:0]    pop_size,
   input  logic [RAND_W-1:0]   rand_a,
   input  logic [RAND_W-1:0]   rand_b,
   output logic [CHOSEN_W-1:0] chosen_index
);

   localparam int NMAX   = (MAX_POP < POP_MAX_REG) ? MAX_POP : POP_MAX_REG;
   localparam int NW     = $clog2(NMAX + 1);
   localparam int IDX_W  = $clog2(MAX_POP);
   localparam int CW     = (NW > IDX_W) ? NW : IDX_W;
   localparam int SQ_W   = $clog2(NMAX * NMAX + 1);
   localparam int TOT_W  = $clog2(NMAX * (NMAX + 1) / 2 + 1);
   localparam int DIFF_W = TOT_W + 1;
   localparam int PRD_W  = RAND_W + TOT_W;
   localparam int SL_W   = RAND_W + NW;

   logic [NW-1:0]     n;
   logic [2*NW-1:0]   sq_full;
   logic [SQ_W:0]     sq_n;
   logic [CW-1:0]     n_m1;

   logic [RAND_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [SQ_W-1:0]   term_ff, term_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [NW-1:0]     round_ff, round_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic signed [DIFF_W-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0]     lo_at_ff, lo_at_in, hi_at_ff, hi_at_in;
   logic              nz_ff, nz_in;
   logic [CW-1:0]     slot_ff, slot_in;
   logic [PRD_W-1:0]  prod_ff, prod_in;
   logic [CHOSEN_W-1:0] out_ff, out_in;

   logic signed [DIFF_W-1:0] diff_mem [MAX_POP];
   logic [IDX_W-1:0]         alias_mem [MAX_POP];
   logic [TOT_W-1:0]         cutoff_mem [MAX_POP];
   logic signed [DIFF_W-1:0] rd_diff_ff;
   logic [IDX_W-1:0]         alias_rd_ff;
   logic [TOT_W-1:0]         cutoff_rd_ff;

   logic signed [SQ_W:0]     init_wide;
   logic signed [DIFF_W-1:0] init_diff;
   logic [DIFF_W:0]          sum_wide;
   logic [DIFF_W:0]          cut_wide;
   logic                     dw_en, aw_en;
   logic [IDX_W-1:0]         dw_addr, aw_addr, aw_alias;
   logic signed [DIFF_W-1:0] dw_data;
   logic [TOT_W-1:0]         aw_cut;
   logic [SL_W-1:0]          an;
   logic [NW-1:0]            slot_raw;
   logic [IDX_W-1:0]         pick;

   // clamp the size register to the supported range
   always_comb begin
      if (pop_size < POP_MIN) begin
         n = NW'(POP_MIN);
      end else if (pop_size > POP_W'(NMAX)) begin
         n = NW'(NMAX);
      end else begin
         n = NW'(pop_size);
      end
   end

   assign sq_full   = n * n;
   assign sq_n      = {1'b0, sq_full[SQ_W-1:0]} + (SQ_W + 1)'(n);
   assign n_m1      = CW'(n) - CW'(1);
   assign init_wide = $signed({1'b0, term_ff})
                      - $signed({{(SQ_W + 1 - TOT_W){1'b0}}, total_ff});
   assign init_diff = init_wide[DIFF_W-1:0];
   assign sum_wide  = {lo_ff[DIFF_W-1], lo_ff} + {hi_ff[DIFF_W-1], hi_ff};
   assign cut_wide  = {2'b00, total_ff} + {lo_ff[DIFF_W-1], lo_ff};
   assign an        = a_ff * n;
   assign slot_raw  = an[SL_W-1:RAND_W];

   always_comb begin
      a_in      = cmd.load_req ? rand_a : a_ff;
      b_in      = cmd.load_req ? rand_b : b_ff;
      total_in  = cmd.prep ? sq_n[TOT_W:1] : total_ff;
      term_in   = term_ff;
      if (cmd.prep) begin
         term_in = sq_full[SQ_W-1:0];
      end else if (cmd.init_wr) begin
         term_in = term_ff - SQ_W'(n);
      end
      cnt_in = cnt_ff;
      if (cmd.prep || cmd.scan_clr) begin
         cnt_in = '0;
      end else if (cmd.init_wr || cmd.scan_rd) begin
         cnt_in = cnt_ff + CW'(1);
      end
      round_in = round_ff;
      if (cmd.prep) begin
         round_in = '0;
      end else if (cmd.wr_hi) begin
         round_in = round_ff + NW'(1);
      end
      rd_vld_in = cmd.scan_rd;
      rd_idx_in = cmd.scan_rd ? cnt_ff : rd_idx_ff;

      lo_in    = lo_ff;
      hi_in    = hi_ff;
      lo_at_in = lo_at_ff;
      hi_at_in = hi_at_ff;
      nz_in    = nz_ff;
      if (cmd.scan_clr) begin
         lo_in    = '0;
         hi_in    = '0;
         lo_at_in = '0;
         hi_at_in = '0;
         nz_in    = 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_diff_ff < lo_ff) begin
            lo_in    = rd_diff_ff;
            lo_at_in = rd_idx_ff;
         end
         if (rd_diff_ff > hi_ff) begin
            hi_in    = rd_diff_ff;
            hi_at_in = rd_idx_ff;
         end
         if (rd_diff_ff != '0) begin
            nz_in = 1'b1;
         end
      end

      slot_in = slot_ff;
      prod_in = prod_ff;
      if (cmd.mul) begin
         slot_in = (slot_raw >= n) ? n_m1 : CW'(slot_raw);
         prod_in = b_ff * total_ff;
      end
      pick   = (prod_ff > {cutoff_rd_ff, RAND_W'(0)}) ? alias_rd_ff : slot_ff[IDX_W-1:0];
      out_in = cmd.out_ld ? CHOSEN_W'(pick) : out_ff;
   end

   // memory write ports
   always_comb begin
      dw_en   = cmd.init_wr | cmd.wr_lo | cmd.wr_hi;
      dw_addr = cnt_ff[IDX_W-1:0];
      dw_data = init_diff;
      if (cmd.wr_lo) begin
         dw_addr = lo_at_ff[IDX_W-1:0];
         dw_data = '0;
      end else if (cmd.wr_hi) begin
         dw_addr = hi_at_ff[IDX_W-1:0];
         dw_data = sum_wide[DIFF_W-1:0];
      end
      aw_en    = cmd.init_wr | cmd.wr_lo;
      aw_addr  = cmd.wr_lo ? lo_at_ff[IDX_W-1:0] : cnt_ff[IDX_W-1:0];
      aw_alias = cmd.wr_lo ? hi_at_ff[IDX_W-1:0] : cnt_ff[IDX_W-1:0];
      aw_cut   = cmd.wr_lo ? cut_wide[TOT_W-1:0] : total_ff;
   end

   always_ff @(posedge clock) begin
      if (dw_en) begin
         diff_mem[dw_addr] <= dw_data;
      end
      if (cmd.scan_rd) begin
         rd_diff_ff <= diff_mem[cnt_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (aw_en) begin
         alias_mem[aw_addr]  <= aw_alias;
         cutoff_mem[aw_addr] <= aw_cut;
      end
      if (cmd.tab_rd) begin
         alias_rd_ff  <= alias_mem[slot_ff[IDX_W-1:0]];
         cutoff_rd_ff <= cutoff_mem[slot_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      total_ff  <= total_in;
      term_ff   <= term_in;
      cnt_ff    <= cnt_in;
      round_ff  <= round_in;
      rd_idx_ff <= rd_idx_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      lo_at_ff  <= lo_at_in;
      hi_at_ff  <= hi_at_in;
      nz_ff     <= nz_in;
      slot_ff   <= slot_in;
      prod_ff   <= prod_in;
      out_ff    <= out_in;
   end

   assign sts.cnt_last   = (cnt_ff == n_m1);
   assign sts.all_zero   = ~nz_ff;
   assign sts.round_done = (round_ff == n);
   assign chosen_index   = out_ff;

endmodule

/* design/rank_weighted_alias_sampler_core.sv */
// Top level of the rank weighted alias sampler: CSR block, controller and
// datapath. Depends on rwas_pkg, rwas_ctrl, rwas_dpath and the assert header.
//
//   channel  handshake              payload
//   req      req_valid / req_stall  req_rand_a, req_rand_b
//   rsp      rsp_valid / rsp_stall  rsp_chosen_index
//   csr      psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//
// With the tables built a request passes through accept, slot multiply, table
// read and cutoff compare.
// The first request after reset or a pop_size write first builds the tables
// in up to n pairing rounds, set by the scan of the difference memory at one
// entry per cycle.
// Reset clears the controller and the table flag and sets pop_size to 50.
// A request is taken while a result waits; the compare step holds until
// the result register is free.
`include "rank_weighted_alias_sampler_core_assert.svh"
module rank_weighted_alias_sampler_core import rwas_pkg::*; #(
   parameter int MAX_POP = MAX_POP_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [RAND_W-1:0]     req_rand_a,
   input  logic [RAND_W-1:0]     req_rand_b,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHOSEN_W-1:0]   rsp_chosen_index,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   rwas_cmd_type         cmd;
   rwas_sts_type         sts;
   logic [POP_W-1:0]     pop_size_ff, pop_size_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 cfg_wr;

   assign csr_idx     = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready  = 1'b1;
   assign cfg_wr      = csr_psel & csr_penable & csr_pwrite & csr_pready
                        & (csr_idx == CSR_POP_SIZE);
   assign pop_size_in = cfg_wr ? csr_pwdata[POP_W-1:0] : pop_size_ff;
   assign csr_prdata  = (csr_idx == CSR_POP_SIZE) ? CSR_DATA_W'(pop_size_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_size_ff <= POP_RESET;
      end else begin
         pop_size_ff <= pop_size_in;
      end
   end

   rwas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cfg_wr    (cfg_wr),
      .sts       (sts),
      .cmd       (cmd)
   );

   rwas_dpath #(
      .MAX_POP (MAX_POP)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .pop_size     (pop_size_ff),
      .rand_a       (req_rand_a),
      .rand_b       (req_rand_b),
      .chosen_index (rsp_chosen_index)
   );

   `RWAS_ASSERT_NEXT(a_one_request, clock, reset, req_valid && !req_stall, req_stall)
   `RWAS_ASSERT_NEXT(a_pair_order, clock, reset, cmd.wr_lo, cmd.wr_hi)
   `RWAS_ASSERT_NOW(a_pair_nonzero, clock, reset, cmd.wr_lo, !sts.all_zero)
   `RWAS_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.out_ld, !(rsp_valid && rsp_stall))

endmodule
